### rtl/root_prefix_word_shortener_defines.svh
// Assertion macros for the root prefix word shortener.
// Included by the top level; expects clk and arst_n in scope.
`ifndef ROOT_PREFIX_WORD_SHORTENER_DEFINES_SVH
`define ROOT_PREFIX_WORD_SHORTENER_DEFINES_SVH

// Checked only out of reset.
`define RPWS_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define RPWS_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/rpws_pkg.sv
// Shared types and constants of the root prefix word shortener.
// No dependencies.
`default_nettype none

package rpws_pkg;

	localparam int SLOT_W    = 6;
	localparam int POS_W     = 5;
	localparam int LETTER_W  = 8;
	localparam int LEN_W     = 6;
	localparam int CFG_W     = 7;
	localparam int S_TDATA_W = 24;
	localparam int M_TDATA_W = 8;

	localparam logic [LETTER_W-1:0] SPACE_CODE = 8'd32;

	localparam logic KIND_LOAD = 1'b0;
	localparam logic KIND_SENT = 1'b1;

	typedef enum logic {
		ST_IDLE,
		ST_EXEC
	} state_t;

endpackage

`default_nettype wire

### rtl/rpws_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`default_nettype none

module rpws_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic                 clk,
	input  wire logic                 we,
	input  wire logic [AW-1:0]        waddr,
	input  wire logic [WIDTH-1:0]     wdata,
	input  wire logic                 re,
	input  wire logic [AW-1:0]        raddr,
	output      logic [WIDTH-1:0]     rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

### rtl/root_prefix_word_shortener.sv
// Top level of the root prefix word shortener: FSM, match lanes, output register.
// Depends on rpws_pkg, rpws_ram and root_prefix_word_shortener_defines.svh.
//
// channel   dir  handshake          payload
// s_*       in   tvalid/tready      tuser=kind, tlast=sentence_end, tdata=load/sentence char
// m_*       out  tvalid/tready      tuser=keep, tlast=last_out, tdata=letter_out
// cfg_*     in   cfg_we             cfg_wdata=root_count
//
// Each item is accepted in ST_IDLE, where the read of one dictionary row (all
// roots' letters at one position) is issued; in ST_EXEC the row is compared
// against the letter, or a load byte is merged and the row written back.
// A sentence item stays in ST_EXEC while the output register is full.
// Reset clears lengths, the live mask and the word state at once; the letter
// memory is not cleared and needs no clearing pass.
`default_nettype none

`include "root_prefix_word_shortener_defines.svh"

module root_prefix_word_shortener
	import rpws_pkg::*;
#(
	parameter int NUM_ROOTS    = 64,
	parameter int MAX_ROOT_LEN = 32
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	// configuration: root_count
	input  wire logic                 cfg_we,
	input  wire logic [CFG_W-1:0]     cfg_wdata,
	// input items
	input  wire logic                 s_tvalid,
	output      logic                 s_tready,
	// tdata from bit 0: slot[5:0], position[10:6], letter[18:11], root_end[19], zero[23:20]
	input  wire logic [S_TDATA_W-1:0] s_tdata,
	// tuser: kind
	input  wire logic                 s_tuser,
	// tlast: sentence_end
	input  wire logic                 s_tlast,
	// result items
	output      logic                 m_tvalid,
	input  wire logic                 m_tready,
	// tdata from bit 0: letter_out[7:0]
	output      logic [M_TDATA_W-1:0] m_tdata,
	// tuser: keep
	output      logic                 m_tuser,
	// tlast: last_out
	output      logic                 m_tlast
);
	localparam int ADDR_W = (MAX_ROOT_LEN > 1) ? $clog2(MAX_ROOT_LEN) : 1;
	localparam int OFF_W  = $clog2(MAX_ROOT_LEN + 1);
	localparam int ROW_W  = NUM_ROOTS * LETTER_W;

	// input field unpack
	logic [SLOT_W-1:0]   in_slot;
	logic [POS_W-1:0]    in_pos;
	logic [LETTER_W-1:0] in_letter;
	logic                in_rend;

	assign in_slot   = s_tdata[SLOT_W-1:0];
	assign in_pos    = s_tdata[SLOT_W +: POS_W];
	assign in_letter = s_tdata[SLOT_W+POS_W +: LETTER_W];
	assign in_rend   = s_tdata[SLOT_W+POS_W+LETTER_W];

	// control state
	state_t              state_q, state_d;
	logic [CFG_W-1:0]    root_count_q;
	logic [LEN_W-1:0]    root_len_q [NUM_ROOTS];
	logic [NUM_ROOTS-1:0] live_q, live_d;
	logic [OFF_W-1:0]    word_off_q, word_off_d;
	logic                skipping_q, skipping_d;
	logic                m_tvalid_q;

	// latched item
	logic                kind_q;
	logic [SLOT_W-1:0]   slot_q;
	logic [POS_W-1:0]    pos_q;
	logic [LETTER_W-1:0] letter_q;
	logic                rend_q;
	logic                send_q;
	logic                ld_ok_q;

	// output payload
	logic [M_TDATA_W-1:0] m_tdata_q;
	logic                 m_tuser_q;
	logic                 m_tlast_q;

	// memory port
	logic                ram_re, ram_we;
	logic [ADDR_W-1:0]   ram_raddr;
	logic [ROW_W-1:0]    rd_row, wr_row;

	logic                out_load;
	logic                keep_d;
	logic                hit;
	logic                in_ld_ok;

	assign in_ld_ok = (32'(in_slot) < NUM_ROOTS) && (32'(in_pos) < MAX_ROOT_LEN);

	// A load reads the row at its position; a sentence char reads the row at the
	// current word offset (don't care once the offset has saturated).
	assign ram_raddr = (s_tuser == KIND_LOAD) ? ADDR_W'(in_pos) : word_off_q[ADDR_W-1:0];

	rpws_ram #(
		.WIDTH(ROW_W),
		.DEPTH(MAX_ROOT_LEN)
	) u_letters (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ADDR_W'(pos_q)),
		.wdata(wr_row),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(rd_row)
	);

	// FSM next state and strobes
	always_comb begin
		state_d  = state_q;
		s_tready = 1'b0;
		ram_re   = 1'b0;
		ram_we   = 1'b0;
		out_load = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					ram_re  = 1'b1;
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (kind_q == KIND_LOAD) begin
					ram_we  = ld_ok_q;
					state_d = ST_IDLE;
				end else if (!m_tvalid_q || m_tready) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// load: replace one byte of the row just read
	always_comb begin
		wr_row = rd_row;
		for (int r = 0; r < NUM_ROOTS; r++) begin
			if (32'(r) == 32'(slot_q)) begin
				wr_row[r*LETTER_W +: LETTER_W] = letter_q;
			end
		end
	end

	// sentence char: one compare lane per root, shortest full match sets skipping
	always_comb begin
		live_d     = live_q;
		word_off_d = word_off_q;
		skipping_d = skipping_q;
		keep_d     = 1'b1;
		hit        = 1'b0;
		priority if (letter_q == SPACE_CODE) begin
			live_d     = '1;
			word_off_d = '0;
			skipping_d = 1'b0;
		end else if (skipping_q) begin
			keep_d = 1'b0;
		end else if (word_off_q < OFF_W'(MAX_ROOT_LEN)) begin
			for (int r = 0; r < NUM_ROOTS; r++) begin
				live_d[r] = live_q[r]
					&& (32'(r) < 32'(root_count_q))
					&& (32'(word_off_q) < 32'(root_len_q[r]))
					&& (rd_row[r*LETTER_W +: LETTER_W] == letter_q);
				if (live_d[r] && (32'(root_len_q[r]) == 32'(word_off_q) + 32'd1)) begin
					hit = 1'b1;
				end
			end
			skipping_d = hit;
			word_off_d = word_off_q + OFF_W'(1);
		end else begin
			// offset at its cap: no root can match, char kept, word state held
		end
		// word state starts over after the sentence's final char
		if (send_q) begin
			live_d     = '1;
			word_off_d = '0;
			skipping_d = 1'b0;
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			root_count_q <= '0;
			live_q       <= '1;
			word_off_q   <= '0;
			skipping_q   <= 1'b0;
			m_tvalid_q   <= 1'b0;
			for (int r = 0; r < NUM_ROOTS; r++) begin
				root_len_q[r] <= '0;
			end
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				root_count_q <= cfg_wdata;
			end
			if (ram_we && rend_q) begin
				for (int r = 0; r < NUM_ROOTS; r++) begin
					if (32'(r) == 32'(slot_q)) begin
						root_len_q[r] <= LEN_W'(pos_q) + LEN_W'(1);
					end
				end
			end
			if (out_load) begin
				live_q     <= live_d;
				word_off_q <= word_off_d;
				skipping_q <= skipping_d;
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// item and result payload
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			kind_q   <= s_tuser;
			slot_q   <= in_slot;
			pos_q    <= in_pos;
			letter_q <= in_letter;
			rend_q   <= in_rend;
			send_q   <= s_tlast;
			ld_ok_q  <= in_ld_ok;
		end
		if (out_load) begin
			m_tdata_q <= letter_q;
			m_tuser_q <= keep_d;
			m_tlast_q <= send_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;
	assign m_tlast  = m_tlast_q;

	// checks
	`RPWS_ASSERT(a_accept_exec, (s_tvalid && s_tready) |=> (state_q == ST_EXEC), "no exec cycle")
	`RPWS_ASSERT(a_out_from_sent, $rose(m_tvalid) |-> $past(out_load), "stray result")
	`RPWS_ASSERT_ALWAYS(a_off_sat, word_off_q <= OFF_W'(MAX_ROOT_LEN), "offset past cap")
	`RPWS_ASSERT_ALWAYS(a_skip_off, skipping_q |-> (word_off_q != '0), "skipping at word start")

endmodule

`default_nettype wire
